// ===== rtl/core/dssfc_pkg.sv =====
// Shared types and constants for the door state sensor fusion controller.
`default_nettype none

package dssfc_pkg;

    // Ultrasonic range limit; readings above it count as no echo
    localparam int unsigned MaxRangeCm = 275;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned DistW     = 9;
    localparam int unsigned IntervalW = 16;
    localparam int unsigned TimeoutW  = 18;
    localparam int unsigned CfgIdxW   = 3;
    localparam int unsigned CfgDataW  = 18;
    localparam int unsigned InDataW   = 48;
    localparam int unsigned OutDataW  = 16;

    typedef enum logic [2:0] {
        DOOR_UNKNOWN = 3'd0,
        DOOR_OPEN    = 3'd1,
        DOOR_CLOSING = 3'd2,
        DOOR_CLOSED  = 3'd3,
        DOOR_OPENING = 3'd4
    } door_mode_t;

    typedef enum logic [2:0] {
        RANGE_UNKNOWN = 3'd0,
        RANGE_ERROR   = 3'd1,
        RANGE_DOOR    = 3'd2,
        RANGE_CAR     = 3'd3,
        RANGE_NODOOR  = 3'd4
    } range_class_t;

    typedef enum logic [1:0] {
        CMD_OPEN        = 2'd0,
        CMD_CLOSE       = 2'd1,
        CMD_FORCE_CLOSE = 2'd2,
        CMD_INVALID     = 2'd3
    } command_kind_t;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_COMMAND = 1'b1
    } opcode_t;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RANGE_IDLE   = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_RANGE_MOVING = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DOOR_MAX     = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_CAR_MAX      = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PRESS_TIME   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_SENSOR_CLEAR = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_MOVE_TIMEOUT = 3'd6;

    // Previous contact level; NONE means no tick seen yet
    localparam logic [1:0] CONTACT_NONE = 2'd2;

    typedef struct packed {
        logic         contact_changed;
        logic         range_class_changed;
        logic         door_state_changed;
        logic         distance_sampled;
        logic         command_accepted;
        range_class_t range_class;
        door_mode_t   door_state;
        logic         relay_on;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/door_state_sensor_fusion_controller.sv =====
// Door state controller: contact and distance fusion, relay press and command handling.
//
// Usage:
//   s_* channel carries one request per item: a periodic tick (tuser = 0) with time,
//   contact level and distance, or a user command (tuser = 1) with time and kind.
//   m_* channel returns exactly one result per request: relay level, door state,
//   range class and event flags.
//   cfg_* channel writes the seven timing and distance registers; write only while
//   no request is in flight. cfg_ready is always high; unknown indexes are dropped.
// Latency and throughput:
//   A result appears on m_tvalid the cycle after its request is taken. One request
//   per cycle is sustained while m_tready holds high; the whole update is one pass of
//   compares and 32-bit time differences between the request and the result register.
// Reset (aresetn low, synchronous):
//   Door and range state return to unknown, relay released, registers to defaults;
//   the first tick afterward always takes a distance sample.
// Stall:
//   While m_tready is low a held result blocks s_tready; state does not advance
//   and no request is taken until the result drains.
`default_nettype none

module door_state_sensor_fusion_controller
    import dssfc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // now_ms[31:0], door_not_closed[32], distance_cm[41:33], command_kind[43:42], zero[47:44]
    input  wire logic [InDataW-1:0]  s_tdata,
    // opcode[0]
    input  wire logic                s_tuser,
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // relay_on[0], door_state[3:1], range_class[6:4], command_accepted[7],
    // distance_sampled[8], door_state_changed[9], range_class_changed[10],
    // contact_changed[11], zero[15:12]
    output logic [OutDataW-1:0]      m_tdata,
    // configuration write channel
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    // Configuration registers
    logic [IntervalW-1:0] range_idle_reg;
    logic [IntervalW-1:0] range_moving_reg;
    logic [DistW-1:0]     door_max_reg;
    logic [DistW-1:0]     car_max_reg;
    logic [IntervalW-1:0] press_time_reg;
    logic [IntervalW-1:0] sensor_clear_reg;
    logic [TimeoutW-1:0]  move_timeout_reg;

    // Controller state
    door_mode_t           door_mode_reg, door_mode_next;
    range_class_t         range_mode_reg, range_mode_next;
    logic [TimeW-1:0]     last_sample_reg, last_sample_next;
    logic                 first_pending_reg, first_pending_next;
    logic                 relay_level_reg, relay_level_next;
    logic                 forcing_reg, forcing_next;
    logic [TimeW-1:0]     press_start_reg, press_start_next;
    logic [TimeW-1:0]     mode_change_reg, mode_change_next;
    door_mode_t           rep_door_reg, rep_door_next;
    range_class_t         rep_range_reg, rep_range_next;
    logic [1:0]           prev_contact_reg, prev_contact_next;

    // Result register
    logic                 m_tvalid_reg;
    result_t              result_reg, result_next;

    // Request fields
    logic                 in_accept;
    opcode_t              in_op;
    logic [TimeW-1:0]     in_now;
    logic                 in_contact;
    logic [DistW-1:0]     in_dist;
    command_kind_t        in_kind;

    // Tick path intermediates
    logic [IntervalW-1:0] interval;
    logic [TimeW-1:0]     el_sample;
    logic [TimeW-1:0]     el_press;
    logic [TimeW-1:0]     el_mode;
    logic [TimeW-1:0]     el_timeout;
    logic                 sample_due;
    logic [DistW-1:0]     dist_eff;
    range_class_t         dist_class;
    range_class_t         tick_range;
    logic                 settle_set;
    logic                 cmd_reject;
    logic                 cmd_accepted;

    assign in_op      = opcode_t'(s_tuser);
    assign in_now     = s_tdata[31:0];
    assign in_contact = s_tdata[32];
    assign in_dist    = s_tdata[41:33];
    assign in_kind    = command_kind_t'(s_tdata[43:42]);

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OutDataW - $bits(result_t)){1'b0}}, result_reg};

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_idle_reg   <= IntervalW'(5000);
            range_moving_reg <= IntervalW'(500);
            door_max_reg     <= DistW'(30);
            car_max_reg      <= DistW'(100);
            press_time_reg   <= IntervalW'(500);
            sensor_clear_reg <= IntervalW'(5000);
            move_timeout_reg <= TimeoutW'(30000);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_RANGE_IDLE:   range_idle_reg   <= cfg_data[IntervalW-1:0];
                CFG_RANGE_MOVING: range_moving_reg <= cfg_data[IntervalW-1:0];
                CFG_DOOR_MAX:     door_max_reg     <= cfg_data[DistW-1:0];
                CFG_CAR_MAX:      car_max_reg      <= cfg_data[DistW-1:0];
                CFG_PRESS_TIME:   press_time_reg   <= cfg_data[IntervalW-1:0];
                CFG_SENSOR_CLEAR: sensor_clear_reg <= cfg_data[IntervalW-1:0];
                CFG_MOVE_TIMEOUT: move_timeout_reg <= cfg_data[TimeoutW-1:0];
                default: ;
            endcase
        end
    end

    // Classify the distance, decide whether a sample is due and check the command
    always_comb begin
        interval = (door_mode_reg == DOOR_OPEN || door_mode_reg == DOOR_CLOSED)
                   ? range_idle_reg : range_moving_reg;
        el_sample  = in_now - last_sample_reg;
        el_press   = in_now - press_start_reg;
        el_mode    = in_now - mode_change_reg;
        sample_due = first_pending_reg || (el_sample >= {16'd0, interval});
        dist_eff   = (in_dist > DistW'(MaxRangeCm)) ? '0 : in_dist;
        priority if (dist_eff == '0)        dist_class = RANGE_ERROR;
        else if (dist_eff <= door_max_reg)  dist_class = RANGE_DOOR;
        else if (dist_eff <= car_max_reg)   dist_class = RANGE_CAR;
        else                                dist_class = RANGE_NODOOR;
        tick_range = sample_due ? dist_class : range_mode_reg;
        cmd_reject = (in_kind == CMD_INVALID) || (relay_level_reg && !forcing_reg)
                     || (in_kind == CMD_CLOSE && door_mode_reg == DOOR_CLOSING)
                     || (in_kind == CMD_OPEN && door_mode_reg == DOOR_OPENING);
        cmd_accepted = !cmd_reject && !forcing_reg;
    end

    // Next state of the door machine and the rest of the controller
    always_comb begin
        door_mode_next     = door_mode_reg;
        range_mode_next    = range_mode_reg;
        last_sample_next   = last_sample_reg;
        first_pending_next = first_pending_reg;
        relay_level_next   = relay_level_reg;
        forcing_next       = forcing_reg;
        press_start_next   = press_start_reg;
        mode_change_next   = mode_change_reg;
        rep_door_next      = rep_door_reg;
        rep_range_next     = rep_range_reg;
        prev_contact_next  = prev_contact_reg;
        settle_set         = 1'b0;
        el_timeout         = el_mode;

        if (in_op == OP_COMMAND) begin
            // Start a press and reverse direction, or release a forced press
            if (!cmd_reject && forcing_reg) begin
                relay_level_next = 1'b0;
                forcing_next     = 1'b0;
            end else if (cmd_accepted) begin
                relay_level_next = 1'b1;
                press_start_next = in_now;
                forcing_next     = (in_kind == CMD_FORCE_CLOSE);
                mode_change_next = in_now;
                door_mode_next   = (door_mode_reg == DOOR_OPEN ||
                                    door_mode_reg == DOOR_OPENING)
                                   ? DOOR_CLOSING : DOOR_OPENING;
            end
        end else begin
            prev_contact_next = {1'b0, in_contact};
            range_mode_next   = tick_range;
            if (sample_due) begin
                last_sample_next   = in_now;
                first_pending_next = 1'b0;
            end

            // Release the relay when its press ends
            if (relay_level_reg) begin
                if (forcing_reg) begin
                    if (!in_contact || el_press >= {14'd0, move_timeout_reg}) begin
                        relay_level_next = 1'b0;
                        forcing_next     = 1'b0;
                    end
                end else if (el_press >= {16'd0, press_time_reg}) begin
                    relay_level_next = 1'b0;
                end
            end

            // Advance the door machine
            unique case (door_mode_reg)
                DOOR_OPEN: begin
                    if (tick_range == RANGE_CAR || tick_range == RANGE_NODOOR) begin
                        door_mode_next   = in_contact ? DOOR_CLOSING : DOOR_CLOSED;
                        mode_change_next = in_now;
                    end
                end
                DOOR_CLOSED: begin
                    if (in_contact) begin
                        door_mode_next   = (tick_range == RANGE_DOOR)
                                           ? DOOR_OPEN : DOOR_OPENING;
                        mode_change_next = in_now;
                    end
                end
                DOOR_CLOSING, DOOR_OPENING: begin
                    if (el_mode >= {16'd0, sensor_clear_reg}) begin
                        if (!in_contact) begin
                            door_mode_next = DOOR_CLOSED;
                            settle_set     = 1'b1;
                        end else if (tick_range == RANGE_DOOR) begin
                            door_mode_next = DOOR_OPEN;
                            settle_set     = 1'b1;
                        end
                    end
                    // A settle just restamped the change time
                    el_timeout = settle_set ? '0 : el_mode;
                    if (el_timeout >= {14'd0, move_timeout_reg}) begin
                        door_mode_next = DOOR_OPEN;
                        settle_set     = 1'b1;
                    end
                    if (settle_set) begin
                        mode_change_next = in_now;
                    end
                end
                default: begin
                    door_mode_next   = in_contact ? DOOR_OPEN : DOOR_CLOSED;
                    mode_change_next = in_now;
                end
            endcase

            rep_range_next = tick_range;
            rep_door_next  = door_mode_next;
        end
    end

    // Build the result for this request
    always_comb begin
        result_next.relay_on            = relay_level_next;
        result_next.door_state          = door_mode_next;
        result_next.range_class         = range_mode_next;
        result_next.command_accepted    = (in_op == OP_COMMAND) && cmd_accepted;
        result_next.distance_sampled    = (in_op == OP_TICK) && sample_due;
        result_next.door_state_changed  = (in_op == OP_TICK) &&
                                          (door_mode_next != rep_door_reg);
        result_next.range_class_changed = (in_op == OP_TICK) &&
                                          (tick_range != rep_range_reg);
        result_next.contact_changed     = (in_op == OP_TICK) &&
                                          (prev_contact_reg != {1'b0, in_contact});
    end

    // Advance state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            door_mode_reg     <= DOOR_UNKNOWN;
            range_mode_reg    <= RANGE_UNKNOWN;
            last_sample_reg   <= '0;
            first_pending_reg <= 1'b1;
            relay_level_reg   <= 1'b0;
            forcing_reg       <= 1'b0;
            press_start_reg   <= '0;
            mode_change_reg   <= '0;
            rep_door_reg      <= DOOR_UNKNOWN;
            rep_range_reg     <= RANGE_UNKNOWN;
            prev_contact_reg  <= CONTACT_NONE;
        end else if (in_accept) begin
            door_mode_reg     <= door_mode_next;
            range_mode_reg    <= range_mode_next;
            last_sample_reg   <= last_sample_next;
            first_pending_reg <= first_pending_next;
            relay_level_reg   <= relay_level_next;
            forcing_reg       <= forcing_next;
            press_start_reg   <= press_start_next;
            mode_change_reg   <= mode_change_next;
            rep_door_reg      <= rep_door_next;
            rep_range_reg     <= rep_range_next;
            prev_contact_reg  <= prev_contact_next;
        end
    end

    // Hold the result until taken; load a new one per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg <= result_next;
        end
    end

    // A forced press always drives the relay
    assert property (@(posedge aclk) disable iff (!aresetn)
        forcing_reg |-> relay_level_reg)
        else $error("forced press without relay drive");

    // An accepted command leaves the relay driven
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && result_reg.command_accepted) |-> result_reg.relay_on)
        else $error("accepted command without relay drive");

    // The first-sample flag clears only through an accepted tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(first_pending_reg) |-> $past(in_accept && in_op == OP_TICK))
        else $error("first sample flag cleared without a tick");

    // An accepted request always yields a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> m_tvalid_reg)
        else $error("accepted request lost its result");

    // Reported door state tracks the live state after every tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_op == OP_TICK) |=> (rep_door_reg == door_mode_reg))
        else $error("reported door state out of step");

endmodule

`default_nettype wire
